@@ hw/rtl/bisulfite_cigar_scorer_defines.svh @@
// Assertion macros for the scorer RTL.
// Included by bcs_back, which has concurrent checks; no other dependencies.
`ifndef BISULFITE_CIGAR_SCORER_DEFINES_SVH
`define BISULFITE_CIGAR_SCORER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define BCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bcs check failed");
// Next-cycle implication, disabled while reset is asserted.
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bcs check failed");
`else
`define BCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/bcs_pkg.sv @@
// Package for the bisulfite CIGAR scorer: codes, constants, types and
// saturating helpers. No dependencies.
`timescale 1ns / 1ps

package bcs_pkg;

	// item operation codes
	localparam logic [1:0] OP_COLUMN = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	// scoring modes
	localparam logic [1:0] MODE_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_VERYFAST = 2'd2;

	// raw base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// register indexes
	localparam logic [2:0] REG_MODE          = 3'd0;
	localparam logic [2:0] REG_COL_BONUS     = 3'd1;
	localparam logic [2:0] REG_MISMATCH_COST = 3'd2;
	localparam logic [2:0] REG_MATCH_SCORE   = 3'd3;
	localparam logic [2:0] REG_MISMATCH_SCORE = 3'd4;
	localparam logic [2:0] REG_GAP_OPEN      = 3'd5;
	localparam logic [2:0] REG_GAP_EXTEND    = 3'd6;

	localparam logic [7:0] FIXED_OPEN = 8'd40;
	localparam logic [7:0] FIXED_EXT  = 8'd6;

	localparam int unsigned CNT_W   = 11;
	localparam int unsigned SCORE_W = 24;
	localparam int unsigned DELTA_W = 21;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int unsigned MAX_READ   = 1024;
	localparam int unsigned READ_LIMIT = (MAX_READ > 2047) ? 2047 : MAX_READ;
	localparam logic [CNT_W-1:0] READ_LIMIT_V = CNT_W'(READ_LIMIT);

	localparam int unsigned BCS_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0]        mode;
		logic [7:0]        col_bonus;
		logic [7:0]        mismatch_cost;
		logic signed [8:0] match_base_score;
		logic signed [8:0] mismatch_base_score;
		logic [7:0]        gap_open_cost;
		logic [7:0]        gap_extend_cost;
	} bcs_cfg_t;

	// one classified word in the queue
	typedef struct packed {
		logic [1:0]                kind;
		logic                      mis;
		logic                      to_alt;
		logic signed [DELTA_W-1:0] delta;
		logic [CNT_W-1:0]          run_length;
		logic [CNT_W-1:0]          read_length;
	} bcs_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0]          matched_count;
		logic [CNT_W-1:0]          inserted_count;
		logic [CNT_W-1:0]          mismatch_count;
		logic [CNT_W-1:0]          gap_run_count;
		logic [CNT_W-1:0]          aligned_length;
		logic signed [SCORE_W-1:0] main_score;
		logic signed [SCORE_W-1:0] alt_score;
		logic                      length_error;
	} bcs_result_t;

	function automatic logic [7:0] gap_open_of(input bcs_cfg_t c);
		return (c.mode != MODE_NORMAL) ? FIXED_OPEN : c.gap_open_cost;
	endfunction

	function automatic logic [7:0] gap_ext_of(input bcs_cfg_t c);
		return (c.mode != MODE_NORMAL) ? FIXED_EXT : c.gap_extend_cost;
	endfunction

	function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic signed [SCORE_W-1:0] score_add(
			input logic signed [SCORE_W-1:0] a, input logic signed [DELTA_W-1:0] d);
		logic signed [SCORE_W:0] s;
		s = (SCORE_W+1)'(a) + (SCORE_W+1)'(d);
		if (s[SCORE_W] != s[SCORE_W-1])
			return s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
		return s[SCORE_W-1:0];
	endfunction

endpackage

@@ hw/rtl/bcs_queue.sv @@
// Short word queue between the scorer front end and back end.
// Depends on bcs_pkg for the entry type.
`timescale 1ns / 1ps

module bcs_queue import bcs_pkg::*; #(
	parameter int unsigned DEPTH = BCS_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bcs_entry_t din,
	output logic       full,
	input  logic       pop,
	output bcs_entry_t dout,
	output logic       empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	bcs_entry_t          slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0]   fill_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (fill_q == FILL_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/bcs_front.sv @@
// Scorer front end: accepts items, classifies them and works out the score delta.
// Depends on bcs_pkg; feeds bcs_queue.
`timescale 1ns / 1ps

module bcs_front import bcs_pkg::*; (
	input  bcs_cfg_t         cfg,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [1:0]       operation,
	input  logic [1:0]       ref_base,
	input  logic [1:0]       read_base,
	input  logic [1:0]       raw_ref_base,
	input  logic [1:0]       raw_read_base,
	input  logic [CNT_W-1:0] run_length,
	input  logic [CNT_W-1:0] read_length,
	input  logic             q_full,
	output logic             q_push,
	output bcs_entry_t       q_din
);

	logic                      fixed_gaps, veryfast, mis;
	logic [7:0]                gopen, gext;
	logic signed [CNT_W:0]     len_adj;
	logic signed [DELTA_W-1:0] prod, cost, col_delta;

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		fixed_gaps = (cfg.mode != MODE_NORMAL);
		veryfast   = (cfg.mode == MODE_VERYFAST);
		gopen      = gap_open_of(cfg);
		gext       = gap_ext_of(cfg);

		mis = (ref_base != read_base)
			|| (raw_ref_base == BASE_T && raw_read_base == BASE_C)
			|| (raw_ref_base == BASE_A && raw_read_base == BASE_G);

		// fixed gaps charge open + L*ext, mode 0 charges open + (L-1)*ext
		len_adj = fixed_gaps ? $signed({1'b0, run_length})
			: $signed({1'b0, run_length}) - (CNT_W+1)'(1);
		prod = DELTA_W'(len_adj) * $signed({{(DELTA_W-8){1'b0}}, gext});
		cost = prod + $signed({{(DELTA_W-8){1'b0}}, gopen});

		if (veryfast) begin
			col_delta = mis ? -$signed({{(DELTA_W-8){1'b0}}, cfg.mismatch_cost})
				: $signed({{(DELTA_W-8){1'b0}}, cfg.col_bonus});
		end else begin
			col_delta = mis ? DELTA_W'(cfg.mismatch_base_score)
				: DELTA_W'(cfg.match_base_score);
		end

		q_din.kind        = operation;
		q_din.mis         = mis;
		q_din.run_length  = run_length;
		q_din.read_length = (read_length > READ_LIMIT_V) ? READ_LIMIT_V : read_length;
		case (operation)
			OP_COLUMN: begin
				q_din.to_alt = veryfast;
				q_din.delta  = col_delta;
			end
			OP_INSERT, OP_DELETE: begin
				q_din.to_alt = !fixed_gaps;
				q_din.delta  = fixed_gaps ? cost : -cost;
			end
			default: begin
				q_din.to_alt = !fixed_gaps;
				q_din.delta  = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/bcs_back.sv @@
// Scorer back end: accumulates counts and scores, settles the finish penalty
// and holds the result word. Depends on bcs_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "bisulfite_cigar_scorer_defines.svh"

module bcs_back import bcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bcs_cfg_t    cfg,
	input  bcs_entry_t  head,
	input  logic        head_valid,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output bcs_result_t result
);

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_FIN = 2'b10
	} back_state_t;

	back_state_t               state_q;
	logic [CNT_W-1:0]          matched_q, inserted_q, mismatch_q, indel_q;
	logic signed [SCORE_W-1:0] main_q, alt_q;
	logic signed [DELTA_W-1:0] pen_q;
	logic                      pen_alt_q, err_q;
	logic                      out_valid_q;
	bcs_result_t               result_q;

	logic                      out_free, is_fin, step, finish;
	logic [CNT_W:0]            tot;
	logic [CNT_W-1:0]          diff;
	logic [CNT_W+8:0]          pen_mag;
	logic signed [DELTA_W-1:0] pen_signed;
	logic signed [SCORE_W-1:0] main_fin, alt_fin;

	assign out_free = !out_valid_q || !result_stall;
	assign is_fin   = (head.kind == OP_FINISH);
	assign step     = (state_q == ST_RUN) && head_valid && !is_fin;
	assign finish   = (state_q == ST_FIN) && out_free;
	assign pop      = step || finish;

	assign result_valid = out_valid_q;
	assign result       = result_q;

	always_comb begin
		tot  = {1'b0, matched_q} + {1'b0, inserted_q};
		diff = head.read_length - tot[CNT_W-1:0];
		pen_mag = (CNT_W+9)'(diff) * (CNT_W+9)'(gap_ext_of(cfg))
			+ (CNT_W+9)'(gap_open_of(cfg));
		if (tot < {1'b0, head.read_length}) begin
			pen_signed = (cfg.mode != MODE_NORMAL) ? $signed({1'b0, pen_mag})
				: -$signed({1'b0, pen_mag});
		end else begin
			pen_signed = '0;
		end
		main_fin = pen_alt_q ? main_q : score_add(main_q, pen_q);
		alt_fin  = pen_alt_q ? score_add(alt_q, pen_q) : alt_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && head_valid && is_fin) begin
			pen_q     <= pen_signed;
			pen_alt_q <= (cfg.mode == MODE_NORMAL);
			err_q     <= (tot > {1'b0, head.read_length});
		end
		if (finish) begin
			result_q.matched_count  <= matched_q;
			result_q.inserted_count <= inserted_q;
			result_q.mismatch_count <= mismatch_q;
			result_q.gap_run_count  <= indel_q;
			result_q.aligned_length <= tot[CNT_W] ? CNT_MAX : tot[CNT_W-1:0];
			result_q.main_score     <= main_fin;
			result_q.alt_score      <= alt_fin;
			result_q.length_error   <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			matched_q   <= '0;
			inserted_q  <= '0;
			mismatch_q  <= '0;
			indel_q     <= '0;
			main_q      <= '0;
			alt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (step) begin
						if (head.to_alt) begin
							alt_q <= score_add(alt_q, head.delta);
						end else begin
							main_q <= score_add(main_q, head.delta);
						end
						if (head.kind == OP_COLUMN) begin
							matched_q <= cnt_add(matched_q, CNT_W'(1));
							if (head.mis) begin
								mismatch_q <= cnt_add(mismatch_q, CNT_W'(1));
							end
						end else begin
							indel_q <= cnt_add(indel_q, CNT_W'(1));
							if (head.kind == OP_INSERT) begin
								inserted_q <= cnt_add(inserted_q, head.run_length);
							end
						end
					end else if (head_valid) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (finish) begin
						matched_q  <= '0;
						inserted_q <= '0;
						mismatch_q <= '0;
						indel_q    <= '0;
						main_q     <= '0;
						alt_q      <= '0;
						state_q    <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	`BCS_ASSERT_IMPLY(a_fin_has_head, clk, arst_n, state_q == ST_FIN, head_valid)
	`BCS_ASSERT_IMPLY(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_FIN)
	`BCS_ASSERT_NEXT(a_clear_after_fin, clk, arst_n, finish, matched_q == '0 && inserted_q == '0 && main_q == '0 && alt_q == '0)

endmodule

@@ hw/rtl/bisulfite_cigar_scorer.sv @@
// Top level of the bisulfite CIGAR scorer: register file, front end, queue, back end.
// Depends on bcs_pkg, bcs_front, bcs_queue and bcs_back.
`timescale 1ns / 1ps

// Scores one alignment streamed as CIGAR words (aligned column, insertion run,
// deletion run, finish) and returns one result word per finish word. The front
// end takes one word per cycle while the queue has room, classifying it and
// working out its score delta (one small multiply) in the accept cycle, and the
// back end folds one column or run word per cycle into the saturating counts
// and scores. A finish word holds the back end while the run state forms the
// unaligned-remainder penalty from the running totals and the finish state then
// applies it and loads the result register once that register is free, so the
// back end takes no new word until a finish is through. Words still queued
// ahead of a finish word and a stalled result push its result later. A
// four-word queue lets the front end keep taking words through a finish or a
// stalled result until it fills. Program the registers over the APB port
// only while no alignment is in flight.

module bisulfite_cigar_scorer import bcs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = BCS_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [4:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// item channel
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [1:0]                operation,
	input  logic [1:0]                ref_base,
	input  logic [1:0]                read_base,
	input  logic [1:0]                raw_ref_base,
	input  logic [1:0]                raw_read_base,
	input  logic [CNT_W-1:0]          run_length,
	input  logic [CNT_W-1:0]          read_length,
	// result channel
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [CNT_W-1:0]          matched_count,
	output logic [CNT_W-1:0]          inserted_count,
	output logic [CNT_W-1:0]          mismatch_count,
	output logic [CNT_W-1:0]          gap_run_count,
	output logic [CNT_W-1:0]          aligned_length,
	output logic signed [SCORE_W-1:0] main_score,
	output logic signed [SCORE_W-1:0] alt_score,
	output logic                      length_error
);

	bcs_cfg_t    cfg_q;
	bcs_entry_t  q_din, q_dout;
	bcs_result_t result;
	logic        q_push, q_pop, q_full, q_empty;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	// Register file: write on the access cycle, ignore addresses past the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode                <= MODE_NORMAL;
			cfg_q.col_bonus           <= 8'd1;
			cfg_q.mismatch_cost       <= 8'd3;
			cfg_q.match_base_score    <= 9'sd0;
			cfg_q.mismatch_base_score <= 9'sd30;
			cfg_q.gap_open_cost       <= FIXED_OPEN;
			cfg_q.gap_extend_cost     <= FIXED_EXT;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MODE:           cfg_q.mode                <= pwdata[1:0];
				REG_COL_BONUS:      cfg_q.col_bonus           <= pwdata[7:0];
				REG_MISMATCH_COST:  cfg_q.mismatch_cost       <= pwdata[7:0];
				REG_MATCH_SCORE:    cfg_q.match_base_score    <= $signed(pwdata[8:0]);
				REG_MISMATCH_SCORE: cfg_q.mismatch_base_score <= $signed(pwdata[8:0]);
				REG_GAP_OPEN:       cfg_q.gap_open_cost       <= pwdata[7:0];
				REG_GAP_EXTEND:     cfg_q.gap_extend_cost     <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back; signed scores come back sign-extended to the bus width.
	always_comb begin
		case (reg_idx)
			REG_MODE:           prdata = {30'd0, cfg_q.mode};
			REG_COL_BONUS:      prdata = {24'd0, cfg_q.col_bonus};
			REG_MISMATCH_COST:  prdata = {24'd0, cfg_q.mismatch_cost};
			REG_MATCH_SCORE:    prdata = 32'(cfg_q.match_base_score);
			REG_MISMATCH_SCORE: prdata = 32'(cfg_q.mismatch_base_score);
			REG_GAP_OPEN:       prdata = {24'd0, cfg_q.gap_open_cost};
			REG_GAP_EXTEND:     prdata = {24'd0, cfg_q.gap_extend_cost};
			default:            prdata = '0;
		endcase
	end

	// Classify each word and work out its delta as it is taken.
	bcs_front u_front (
		.cfg           (cfg_q),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.ref_base      (ref_base),
		.read_base     (read_base),
		.raw_ref_base  (raw_ref_base),
		.raw_read_base (raw_read_base),
		.run_length    (run_length),
		.read_length   (read_length),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_din         (q_din)
	);

	// Decouple the halves: a finish or a stalled result stalls intake only when full.
	bcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// Accumulate, settle the remainder penalty and hold the result word.
	bcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (q_dout),
		.head_valid   (!q_empty),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign matched_count  = result.matched_count;
	assign inserted_count = result.inserted_count;
	assign mismatch_count = result.mismatch_count;
	assign gap_run_count  = result.gap_run_count;
	assign aligned_length = result.aligned_length;
	assign main_score     = result.main_score;
	assign alt_score      = result.alt_score;
	assign length_error   = result.length_error;

endmodule

@@ tb/bisulfite_cigar_scorer_tb.sv @@
// Self-checking testbench for bisulfite_cigar_scorer: streams CIGAR words, programs the
// registers over APB and checks every finish result against a scoreboard of its own.
// Depends on bcs_pkg and the scorer RTL; reads nothing else.
`timescale 1ns / 1ps

import bcs_pkg::*;

// one CIGAR word as offered on the item channel
typedef struct {
	logic [1:0]       op;
	logic [1:0]       ref_b;
	logic [1:0]       read_b;
	logic [1:0]       raw_ref_b;
	logic [1:0]       raw_read_b;
	logic [CNT_W-1:0] run_len;
	logic [CNT_W-1:0] read_len;
} cigar_word_t;

// Keeps its own copy of the registers and the running alignment totals, and
// holds the totals expected from each finish word until the block returns them.
class alignment_scoreboard;
	logic [1:0]  mode;
	int          bonus, penalty, match_pts, mismatch_pts, open_cost, ext_cost;
	int          matched, inserted, mism, indels;
	longint      main_acc, alt_acc;
	bcs_result_t totals_q[$];
	int          failures, mismatches;

	function new();
		mode         = MODE_NORMAL;
		bonus        = 1;
		penalty      = 3;
		match_pts    = 0;
		mismatch_pts = 30;
		open_cost    = 40;
		ext_cost     = 6;
		failures     = 0;
		mismatches   = 0;
		clear_run();
	endfunction

	function void clear_run();
		matched  = 0;
		inserted = 0;
		mism     = 0;
		indels   = 0;
		main_acc = 0;
		alt_acc  = 0;
	endfunction

	function int pending();
		return totals_q.size();
	endfunction

	function void set_reg(input int idx, input logic [31:0] v);
		case (idx)
			REG_MODE:           mode = v[1:0];
			REG_COL_BONUS:      bonus = v[7:0];
			REG_MISMATCH_COST:  penalty = v[7:0];
			REG_MATCH_SCORE:    match_pts = $signed(v[8:0]);
			REG_MISMATCH_SCORE: mismatch_pts = $signed(v[8:0]);
			REG_GAP_OPEN:       open_cost = v[7:0];
			REG_GAP_EXTEND:     ext_cost = v[7:0];
			default: ;
		endcase
	endfunction

	function int bump(input int a, input int b);
		return (a + b > int'(CNT_MAX)) ? int'(CNT_MAX) : a + b;
	endfunction

	function longint clamp(input longint v);
		if (v > longint'(8388607))
			return 8388607;
		if (v < -longint'(8388608))
			return -8388608;
		return v;
	endfunction

	function void note_word(input cigar_word_t w);
		bit          fixed, vfast, mis;
		longint      gopen, gext, len, gap;
		int          slen, tot;
		bcs_result_t r;
		fixed = (mode != MODE_NORMAL);
		vfast = (mode == MODE_VERYFAST);
		gopen = fixed ? longint'(FIXED_OPEN) : longint'(open_cost);
		gext  = fixed ? longint'(FIXED_EXT) : longint'(ext_cost);
		len   = w.run_len;
		case (w.op)
			OP_COLUMN: begin
				mis = (w.ref_b != w.read_b)
					|| (w.raw_ref_b == BASE_T && w.raw_read_b == BASE_C)
					|| (w.raw_ref_b == BASE_A && w.raw_read_b == BASE_G);
				if (mis) begin
					mism = bump(mism, 1);
					if (vfast)
						alt_acc = clamp(alt_acc - penalty);
					else
						main_acc = clamp(main_acc + mismatch_pts);
				end else if (vfast) begin
					alt_acc = clamp(alt_acc + bonus);
				end else begin
					main_acc = clamp(main_acc + match_pts);
				end
				matched = bump(matched, 1);
			end
			OP_INSERT, OP_DELETE: begin
				if (w.op == OP_INSERT)
					inserted = bump(inserted, w.run_len);
				indels = bump(indels, 1);
				if (fixed)
					main_acc = clamp(main_acc + gopen + len * gext);
				else
					alt_acc = clamp(alt_acc - (gopen + (len - 1) * gext));
			end
			default: begin
				slen = w.read_len;
				if (slen > int'(READ_LIMIT))
					slen = READ_LIMIT;
				tot = matched + inserted;
				r.length_error = 1'b0;
				if (tot < slen) begin
					gap = slen - tot;
					if (fixed)
						main_acc = clamp(main_acc + gopen + gap * gext);
					else
						alt_acc = clamp(alt_acc - (gopen + gap * gext));
				end else if (tot > slen) begin
					r.length_error = 1'b1;
				end
				r.matched_count  = matched;
				r.inserted_count = inserted;
				r.mismatch_count = mism;
				r.gap_run_count  = indels;
				r.aligned_length = bump(matched, inserted);
				r.main_score     = main_acc[SCORE_W-1:0];
				r.alt_score      = alt_acc[SCORE_W-1:0];
				totals_q.push_back(r);
				clear_run();
			end
		endcase
	endfunction

	function void compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			failures++;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		end
	endfunction

	function void check_result(input bcs_result_t got);
		bcs_result_t want;
		if (totals_q.size() == 0) begin
			failures++;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result word with no finish word waiting", $realtime);
			return;
		end
		want = totals_q.pop_front();
		compare_field("matched_count", want.matched_count, got.matched_count);
		compare_field("inserted_count", want.inserted_count, got.inserted_count);
		compare_field("mismatch_count", want.mismatch_count, got.mismatch_count);
		compare_field("gap_run_count", want.gap_run_count, got.gap_run_count);
		compare_field("aligned_length", want.aligned_length, got.aligned_length);
		compare_field("main_score", $signed(want.main_score), $signed(got.main_score));
		compare_field("alt_score", $signed(want.alt_score), $signed(got.alt_score));
		compare_field("length_error", want.length_error, got.length_error);
	endfunction
endclass

module bisulfite_cigar_scorer_tb;

	localparam int unsigned RESET_CYCLES  = 11;
	// queue of four plus the finish in the back end, with margin
	localparam int unsigned SETTLE_CYCLES = 24;
	// several times the longest quiet stretch of a correct run (drain, register
	// writes and the longest result stall back to back)
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned PHASE_WORDS   = 110;
	localparam int unsigned SAT_RUNS      = 690;

	localparam logic [1:0]       MODE_FAST  = 2'd1;
	localparam logic [1:0]       MODE_SPARE = 2'd3;   // undocumented, acts like fast
	localparam logic [2:0]       REG_UNUSED = 3'd7;
	localparam logic [CNT_W-1:0] RUN_MAX    = '1;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_style_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [4:0]                paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      item_valid = 1'b0;
	logic                      item_stall;
	logic [1:0]                operation = '0;
	logic [1:0]                ref_base = '0;
	logic [1:0]                read_base = '0;
	logic [1:0]                raw_ref_base = '0;
	logic [1:0]                raw_read_base = '0;
	logic [CNT_W-1:0]          run_length = '0;
	logic [CNT_W-1:0]          read_length = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic [CNT_W-1:0]          matched_count;
	logic [CNT_W-1:0]          inserted_count;
	logic [CNT_W-1:0]          mismatch_count;
	logic [CNT_W-1:0]          gap_run_count;
	logic [CNT_W-1:0]          aligned_length;
	logic signed [SCORE_W-1:0] main_score;
	logic signed [SCORE_W-1:0] alt_score;
	logic                      length_error;

	alignment_scoreboard sb;
	bcs_result_t         seen;
	bit                  offering = 1'b0;   // mirrors item_valid as last driven
	int                  burst_left = 0;
	int                  words_sent = 0;
	stall_style_t        stall_style = STALL_NONE;
	int                  style_left = 0;
	int                  wave_phase = 0;
	logic [1:0]          phase_modes [4] = '{MODE_NORMAL, MODE_FAST, MODE_VERYFAST, MODE_SPARE};

	bisulfite_cigar_scorer u_top (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: check each accepted word, then pick the stall for the next
	// cycle. The stall style is redrawn at random after a random stretch, so there are
	// stretches with no stall at all as well as light, heavy and periodic back-pressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				seen.matched_count  = matched_count;
				seen.inserted_count = inserted_count;
				seen.mismatch_count = mismatch_count;
				seen.gap_run_count  = gap_run_count;
				seen.aligned_length = aligned_length;
				seen.main_score     = main_score;
				seen.alt_score      = alt_score;
				seen.length_error   = length_error;
				sb.check_result(seen);
			end
			if (style_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				style_left  = $urandom_range(50, 300);
			end
			style_left--;
			case (stall_style)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					wave_phase++;
					result_stall <= ((wave_phase % 7) < 3);
				end
			endcase
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic cigar_word_t make_word(input logic [1:0] op, input logic [1:0] rb,
			input logic [1:0] qb, input logic [1:0] rrb, input logic [1:0] rqb,
			input logic [CNT_W-1:0] run, input logic [CNT_W-1:0] rlen);
		cigar_word_t w;
		w.op         = op;
		w.ref_b      = rb;
		w.read_b     = qb;
		w.raw_ref_b  = rrb;
		w.raw_read_b = rqb;
		w.run_len    = run;
		w.read_len   = rlen;
		return w;
	endfunction

	// every field fully random, finish words included
	function automatic cigar_word_t noise_word();
		return make_word(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
			2'($urandom), CNT_W'($urandom), CNT_W'($urandom));
	endfunction

	// Offer one word and hold it until it is taken, then note it. At the end of a
	// burst usually drop valid for a random gap; otherwise keep valid high for the next word.
	task automatic send_word(input cigar_word_t w);
		int gap;
		item_valid    <= 1'b1;
		offering      = 1'b1;
		operation     <= w.op;
		ref_base      <= w.ref_b;
		read_base     <= w.read_b;
		raw_ref_base  <= w.raw_ref_b;
		raw_read_base <= w.raw_read_b;
		run_length    <= w.run_len;
		read_length   <= w.read_len;
		do @(posedge clk); while (item_stall);
		sb.note_word(w);
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				offering   = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering, wait for every expected result, then let the back end settle.
	task automatic drain();
		if (offering) begin
			item_valid <= 1'b0;
			offering   = 1'b0;
		end
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup cycle, access cycle, then an idle cycle so writes never abut
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write every register; the unused upper data bits carry noise
	task automatic program_regs(input logic [1:0] m, input logic [7:0] bonus,
			input logic [7:0] cost, input logic [8:0] match_pts,
			input logic [8:0] mismatch_pts, input logic [7:0] open_c, input logic [7:0] ext_c);
		write_reg(REG_MODE, {30'($urandom), m});
		write_reg(REG_COL_BONUS, {24'($urandom), bonus});
		write_reg(REG_MISMATCH_COST, {24'($urandom), cost});
		write_reg(REG_MATCH_SCORE, {23'($urandom), match_pts});
		write_reg(REG_MISMATCH_SCORE, {23'($urandom), mismatch_pts});
		write_reg(REG_GAP_OPEN, {24'($urandom), open_c});
		write_reg(REG_GAP_EXTEND, {24'($urandom), ext_c});
	endtask

	// One well-formed alignment: mostly columns, some runs, then a finish whose
	// read length sits on, just above or just below the aligned length, or is random.
	task automatic send_alignment(input int max_items);
		int         n, tot, pick, len, slen;
		logic [1:0] rb, qb, rrb, rqb, op;
		n   = $urandom_range(0, max_items);
		tot = 0;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			rb   = 2'($urandom);
			qb   = ($urandom_range(0, 9) < 7) ? rb : 2'($urandom);
			rrb  = 2'($urandom);
			rqb  = 2'($urandom);
			if (pick < 75) begin
				// steer some columns onto the bisulfite pairs
				if ($urandom_range(0, 3) == 0)
					rqb = (rrb == BASE_T) ? BASE_C : (rrb == BASE_A) ? BASE_G : rqb;
				send_word(make_word(OP_COLUMN, rb, qb, rrb, rqb,
					CNT_W'($urandom), CNT_W'($urandom)));
				tot++;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = 0;
				else if (pick < 85)
					len = $urandom_range(1, 8);
				else if (pick < 97)
					len = $urandom_range(9, 100);
				else
					len = $urandom_range(101, 2047);
				op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_DELETE;
				send_word(make_word(op, rb, qb, rrb, rqb, CNT_W'(len), CNT_W'($urandom)));
				if (op == OP_INSERT)
					tot += len;
			end
		end
		pick = $urandom_range(0, 99);
		if (pick < 30)
			slen = tot;
		else if (pick < 70)
			slen = tot + $urandom_range(1, 20);
		else if (pick < 85)
			slen = tot - $urandom_range(1, 3);
		else
			slen = $urandom_range(0, 2047);
		if (slen < 0)
			slen = 0;
		if (slen > 2047)
			slen = 2047;
		send_word(make_word(OP_FINISH, 2'($urandom), 2'($urandom), 2'($urandom),
			2'($urandom), CNT_W'($urandom), CNT_W'(slen)));
	endtask

	initial begin : stimulus
		int         k, target;
		logic [7:0] b, c, o, e;
		logic [8:0] ms, mm;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset register values.
		send_word(make_word(OP_COLUMN, BASE_A, BASE_A, BASE_A, BASE_A, '0, '0));
		// converted bases differ
		send_word(make_word(OP_COLUMN, BASE_C, BASE_G, BASE_C, BASE_C, RUN_MAX, RUN_MAX));
		// raw T against raw C with equal converted bases
		send_word(make_word(OP_COLUMN, BASE_T, BASE_T, BASE_T, BASE_C, '0, RUN_MAX));
		// raw A against raw G with equal converted bases
		send_word(make_word(OP_COLUMN, BASE_G, BASE_G, BASE_A, BASE_G, RUN_MAX, '0));
		send_word(make_word(OP_COLUMN, BASE_T, BASE_T, BASE_T, BASE_T, '0, '0));
		send_word(make_word(OP_INSERT, BASE_A, BASE_C, BASE_G, BASE_T, 11'd1, '0));
		send_word(make_word(OP_DELETE, BASE_T, BASE_G, BASE_C, BASE_A, RUN_MAX, '0));
		// zero-length runs
		send_word(make_word(OP_INSERT, BASE_A, BASE_A, BASE_A, BASE_A, '0, '0));
		send_word(make_word(OP_DELETE, BASE_A, BASE_A, BASE_A, BASE_A, '0, '0));
		// read length far above the limit: clamp it, then charge the remainder
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, RUN_MAX));
		// one column against an empty read: overlength
		send_word(make_word(OP_COLUMN, BASE_C, BASE_C, BASE_C, BASE_C, '0, '0));
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, '0));
		// exact fit: no penalty, no overlength
		send_word(make_word(OP_COLUMN, BASE_G, BASE_C, BASE_A, BASE_G, '0, '0));
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, 11'd1));
		// insert count saturates, read length one past the limit
		send_word(make_word(OP_INSERT, BASE_A, BASE_A, BASE_A, BASE_A, RUN_MAX, '0));
		send_word(make_word(OP_INSERT, BASE_A, BASE_A, BASE_A, BASE_A, RUN_MAX, '0));
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, 11'd1025));
		// bare finishes: full remainder, then all zero
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, 11'd1024));
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, '0));
		drain();

		// Drive the main score into positive saturation with long fixed-cost runs.
		program_regs(MODE_FAST, 8'($urandom), 8'($urandom), 9'($urandom), 9'($urandom),
			8'($urandom), 8'($urandom));
		repeat (SAT_RUNS)
			send_word(make_word(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_DELETE,
				2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), RUN_MAX,
				CNT_W'($urandom)));
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, CNT_W'($urandom)));
		drain();

		// Drive the alternate score into negative saturation with the costliest gaps.
		program_regs(MODE_NORMAL, 8'($urandom), 8'($urandom), 9'($urandom), 9'($urandom),
			8'd255, 8'd255);
		repeat (20)
			send_word(make_word(OP_DELETE, 2'($urandom), 2'($urandom), 2'($urandom),
				2'($urandom), RUN_MAX, CNT_W'($urandom)));
		send_word(make_word(OP_FINISH, BASE_A, BASE_A, BASE_A, BASE_A, '0, '0));
		drain();
		// a write past the last register must change nothing
		write_reg(REG_UNUSED, $urandom);

		// Random phases: walk all four modes twice over maximum, minimum and random
		// register sets, mostly well-formed alignments with some noise words mixed in.
		for (k = 0; k < 8; k++) begin
			case (k % 3)
				0: begin
					b = 8'd255; c = 8'd255; ms = 9'sd255; mm = -9'sd255;
					o = 8'd255; e = 8'd255;
				end
				1: begin
					b = 8'd0; c = 8'd0; ms = -9'sd255; mm = 9'sd255;
					o = 8'd0; e = 8'd0;
				end
				default: begin
					b = 8'($urandom); c = 8'($urandom); ms = 9'($urandom); mm = 9'($urandom);
					o = 8'($urandom); e = 8'($urandom);
				end
			endcase
			program_regs(phase_modes[k % 4], b, c, ms, mm, o, e);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(noise_word());
				end else begin
					send_alignment(30);
					// now and then hold off until every result is back
					if ($urandom_range(0, 14) == 0)
						drain();
				end
			end
			// close the alignment in flight before the registers change
			send_word(make_word(OP_FINISH, 2'($urandom), 2'($urandom), 2'($urandom),
				2'($urandom), CNT_W'($urandom), CNT_W'($urandom)));
			drain();
		end

		drain();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
